[hdl/fbpa_pkg.sv]
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared widths, codes and defaults for the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

   // field widths of the request and response channels
   localparam int unsigned ADDR_W     = 48;
   localparam int unsigned BYTES_W    = 32;
   localparam int unsigned FB_W       = 33;
   localparam int unsigned FREE_W     = 11;
   localparam int unsigned REQ_TYPE_W = 2;
   localparam int unsigned STATUS_W   = 3;

   // allocation granularity in bytes
   localparam int unsigned ALLOC_ALIGN = 8;

   // default pool geometry
   localparam int unsigned POOL_BLOCKS_DEF = 1024;
   localparam int unsigned BLOCK_BYTES_DEF = 1024;

   // request kinds; the fourth code is rejected with an error status
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_ALLOC  = 2'd0,
      REQ_FREE   = 2'd1,
      REQ_RESIZE = 2'd2
   } req_kind_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_GRANT          = 3'd0,
      STAT_GENERAL        = 3'd1,
      STAT_FREED          = 3'd2,
      STAT_FOREIGN_FREE   = 3'd3,
      STAT_KEPT           = 3'd4,
      STAT_MOVED          = 3'd5,
      STAT_FOREIGN_RESIZE = 3'd6,
      STAT_ERROR          = 3'd7
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_DIVIDE,
      FSM_ACCESS,
      FSM_UPDATE
   } state_type;

endpackage

[hdl/fbpa_req_if.sv]
// ----------------------------------------------------------------------------
// fbpa_req_if
// Request channel: valid/ready handshake carrying one allocator request.
// ----------------------------------------------------------------------------
interface fbpa_req_if import fbpa_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [BYTES_W-1:0]    request_bytes;
   logic [ADDR_W-1:0]     address;

   modport source (output valid, req_type, request_bytes, address, input ready);
   modport sink   (input valid, req_type, request_bytes, address, output ready);

endinterface

[hdl/fbpa_rsp_if.sv]
// ----------------------------------------------------------------------------
// fbpa_rsp_if
// Response channel: valid/ready handshake carrying one allocator result.
// ----------------------------------------------------------------------------
interface fbpa_rsp_if import fbpa_pkg::*; ();

   logic              valid;
   logic              ready;
   status_type        status;
   logic [ADDR_W-1:0] block_address;
   logic [FB_W-1:0]   fallback_bytes;
   logic [FREE_W-1:0] free_blocks;
   logic              pool_all_free;

   modport source (output valid, status, block_address, fallback_bytes, free_blocks,
                   pool_all_free, input ready);
   modport sink   (input valid, status, block_address, fallback_bytes, free_blocks,
                   pool_all_free, output ready);

endinterface

[hdl/fixed_block_pool_allocator_unit.sv]
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit
// Fixed-size block pool allocator with a free-index stack and used bits in RAM.
// ----------------------------------------------------------------------------
// Hands out blocks of BLOCK_BYTES bytes from a pool of POOL_BLOCKS blocks laid
// out from the base address in the csr register, and returns one response per
// request transfer. After reset the block runs an init pass that loads the free
// stack and clears the used bits; req ready stays low until it ends (csr writes
// are taken throughout). With BLOCK_BYTES a power of two a request goes through
// the idle state, which takes the transfer and reads the stack top and the used
// bit, then the update state, which updates both RAMs and loads the response
// register. Otherwise a request whose address falls in the pool also passes
// a divide state, for a reciprocal multiply that turns the pool offset into
// the block index, and an access state that reads that block's used bit.
// A stalled response holds the update step until the response register frees
// up; that register holds one result, so the next request is taken while a
// result waits. The pool never hands out a block that sits on the stack with
// its used bit set: the stack holds exactly the blocks whose used bit is clear.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_unit import fbpa_pkg::*; #(
   parameter int unsigned POOL_BLOCKS = POOL_BLOCKS_DEF,
   parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   fbpa_req_if.sink          req_chan,
   fbpa_rsp_if.source        rsp_chan,
   input  logic              csr_write_enable,
   input  logic [ADDR_W-1:0] csr_write_data
);

   localparam int unsigned IDX_W     = $clog2(POOL_BLOCKS);
   localparam int unsigned DEPTH_W   = $clog2(POOL_BLOCKS + 1);
   localparam int unsigned BLK_W     = $clog2(BLOCK_BYTES + 1);
   localparam int unsigned BLK_SHIFT = $clog2(BLOCK_BYTES);
   localparam int unsigned GRANT_W   = IDX_W + BLK_W;
   localparam int unsigned OFF_W     =
      $clog2(longint'(POOL_BLOCKS) * longint'(BLOCK_BYTES));
   localparam int unsigned RCP_SHIFT = OFF_W + BLK_SHIFT;
   localparam int unsigned RCP_W     = OFF_W + 1;
   localparam int unsigned PROD_W    = OFF_W + RCP_W;
   localparam bit          BLK_POW2  = ((BLOCK_BYTES & (BLOCK_BYTES - 1)) == 0);

   localparam logic [ADDR_W-1:0]  POOL_SPAN  =
      ADDR_W'(longint'(POOL_BLOCKS) * longint'(BLOCK_BYTES));
   localparam logic [DEPTH_W-1:0] POOL_DEPTH = DEPTH_W'(POOL_BLOCKS);
   localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(POOL_BLOCKS - 1);
   // ceil(2^RCP_SHIFT / BLOCK_BYTES), exact quotient for every pool offset
   localparam logic [RCP_W-1:0]   RCP_MUL    =
      RCP_W'(((longint'(1) << RCP_SHIFT) + longint'(BLOCK_BYTES) - longint'(1)) /
             longint'(BLOCK_BYTES));
   localparam logic [FB_W-1:0]    ALIGN_MASK = FB_W'(ALLOC_ALIGN - 1);
   localparam logic [FB_W-1:0]    BLOCK_SIZE = FB_W'(BLOCK_BYTES);

   // storage
   logic [IDX_W-1:0] stack_mem [POOL_BLOCKS];
   logic             used_mem  [POOL_BLOCKS];

   // control state
   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    clr_ff, clr_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // request and index registers
   logic [REQ_TYPE_W-1:0] kind_ff;
   logic [BYTES_W-1:0]    bytes_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [FB_W-1:0]       rounded_ff;
   logic                  alloc_fits_ff;
   logic                  resize_fits_ff;
   logic                  owned_ff;
   logic [OFF_W-1:0]      off_ff;
   logic [IDX_W-1:0]      idx_ff, idx_in;

   // memory read data
   logic [IDX_W-1:0] stk_q_ff;
   logic             used_q_ff;

   // response registers
   status_type        status_ff;
   logic [ADDR_W-1:0] baddr_ff;
   logic [FB_W-1:0]   fb_ff;
   logic [FREE_W-1:0] free_ff;
   logic              all_free_ff;

   // combinational
   logic               req_transfer;
   logic               slot_free;
   logic               req_ready;
   logic               clearing;
   logic               stk_re;
   logic               used_re;
   logic               update_fire;
   logic [ADDR_W-1:0]  off_comb;
   logic               owned_comb;
   logic [IDX_W-1:0]   idx_direct;
   logic [FB_W-1:0]    rounded_comb;
   logic [PROD_W-1:0]  quot_prod;
   logic [GRANT_W-1:0] grant_off;
   logic [ADDR_W-1:0]  grant_addr;
   logic               release_ok;
   logic               grant;
   logic               release_blk;
   status_type         status_in;
   logic [ADDR_W-1:0]  baddr_in;
   logic [FB_W-1:0]    fb_in;
   logic [DEPTH_W-1:0] depth_next;
   logic               stk_we;
   logic [IDX_W-1:0]   stk_waddr;
   logic [IDX_W-1:0]   stk_wdata;
   logic [IDX_W-1:0]   stk_raddr;
   logic               used_we;
   logic [IDX_W-1:0]   used_waddr;
   logic               used_wdata;
   logic [IDX_W-1:0]   used_raddr;

   // channel hookup
   assign req_chan.ready          = req_ready;
   assign req_transfer            = req_chan.valid && req_ready;
   assign slot_free               = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.block_address  = baddr_ff;
   assign rsp_chan.fallback_bytes = fb_ff;
   assign rsp_chan.free_blocks    = free_ff;
   assign rsp_chan.pool_all_free  = all_free_ff;

   // ownership and direct index from the incoming address
   assign off_comb     = req_chan.address - base_ff;
   assign owned_comb   = (req_chan.address >= base_ff) && (off_comb < POOL_SPAN);
   assign idx_direct   = off_comb[BLK_SHIFT +: IDX_W];
   assign rounded_comb = ({1'b0, req_chan.request_bytes} + ALIGN_MASK) & ~ALIGN_MASK;

   // block index by reciprocal multiply of the registered offset
   assign quot_prod = PROD_W'(off_ff) * PROD_W'(RCP_MUL);

   // grant address from the popped index
   assign grant_off  = GRANT_W'(stk_q_ff) * GRANT_W'(BLOCK_BYTES);
   assign grant_addr = base_ff + ADDR_W'(grant_off);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_CLEAR: begin
            if (clr_ff == LAST_IDX) state_in = FSM_IDLE;
         end
         FSM_IDLE: begin
            if (req_transfer) begin
               state_in = (!BLK_POW2 && owned_comb) ? FSM_DIVIDE : FSM_UPDATE;
            end
         end
         FSM_DIVIDE: begin
            state_in = FSM_ACCESS;
         end
         FSM_ACCESS: begin
            state_in = FSM_UPDATE;
         end
         FSM_UPDATE: begin
            if (slot_free) state_in = FSM_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready   = (state_ff == FSM_IDLE);
      clearing    = (state_ff == FSM_CLEAR);
      stk_re      = (state_ff == FSM_IDLE);
      used_re     = (state_ff == FSM_IDLE) || (state_ff == FSM_ACCESS);
      update_fire = (state_ff == FSM_UPDATE) && slot_free;
   end

   // request decision
   always_comb begin
      status_in   = STAT_ERROR;
      baddr_in    = '0;
      fb_in       = '0;
      grant       = 1'b0;
      release_blk = 1'b0;
      release_ok  = used_q_ff && (depth_ff < POOL_DEPTH);
      unique case (kind_ff)
         REQ_ALLOC: begin
            if (alloc_fits_ff && (depth_ff != '0)) begin
               grant     = 1'b1;
               status_in = STAT_GRANT;
               baddr_in  = grant_addr;
            end else begin
               status_in = STAT_GENERAL;
               fb_in     = rounded_ff;
            end
         end
         REQ_FREE: begin
            priority if (!owned_ff) begin
               status_in = STAT_FOREIGN_FREE;
               baddr_in  = addr_ff;
            end else if (release_ok) begin
               release_blk = 1'b1;
               status_in   = STAT_FREED;
               baddr_in    = addr_ff;
            end
         end
         REQ_RESIZE: begin
            priority if (!owned_ff) begin
               status_in = STAT_FOREIGN_RESIZE;
               baddr_in  = addr_ff;
               fb_in     = FB_W'(bytes_ff);
            end else if (resize_fits_ff) begin
               status_in = STAT_KEPT;
               baddr_in  = addr_ff;
            end else if (release_ok) begin
               release_blk = 1'b1;
               status_in   = STAT_MOVED;
               baddr_in    = addr_ff;
               fb_in       = FB_W'(bytes_ff);
            end
         end
         default: begin
            status_in = STAT_ERROR;
         end
      endcase
   end

   // stack depth after this request
   always_comb begin
      priority if (grant) depth_next = depth_ff - DEPTH_W'(1);
      else if (release_blk) depth_next = depth_ff + DEPTH_W'(1);
      else depth_next = depth_ff;
   end

   // memory ports: init pass or update write-back
   always_comb begin
      stk_raddr  = IDX_W'(depth_ff - DEPTH_W'(1));
      used_raddr = (state_ff == FSM_ACCESS) ? idx_ff : idx_direct;
      stk_we     = clearing || (update_fire && release_blk);
      stk_waddr  = clearing ? clr_ff : depth_ff[IDX_W-1:0];
      stk_wdata  = clearing ? clr_ff : idx_ff;
      used_we    = clearing || (update_fire && (grant || release_blk));
      used_waddr = clearing ? clr_ff : (grant ? stk_q_ff : idx_ff);
      used_wdata = !clearing && grant;
   end

   // next values of the control registers
   always_comb begin
      clr_in       = clearing ? clr_ff + IDX_W'(1) : clr_ff;
      depth_in     = update_fire ? depth_next : depth_ff;
      base_in      = csr_write_enable ? csr_write_data : base_ff;
      rsp_valid_in = update_fire ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   // block index
   always_comb begin
      idx_in = idx_ff;
      if (req_transfer) idx_in = idx_direct;
      else if (state_ff == FSM_DIVIDE) idx_in = quot_prod[RCP_SHIFT +: IDX_W];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_CLEAR;
         clr_ff       <= '0;
         depth_ff     <= POOL_DEPTH;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         depth_ff     <= depth_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request capture and index register
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         kind_ff        <= req_chan.req_type;
         bytes_ff       <= req_chan.request_bytes;
         addr_ff        <= req_chan.address;
         rounded_ff     <= rounded_comb;
         alloc_fits_ff  <= (rounded_comb <= BLOCK_SIZE);
         resize_fits_ff <= ({1'b0, req_chan.request_bytes} <= BLOCK_SIZE);
         owned_ff       <= owned_comb;
         off_ff         <= off_comb[OFF_W-1:0];
      end
      idx_ff <= idx_in;
   end

   // response register
   always_ff @(posedge clock) begin
      if (update_fire) begin
         status_ff   <= status_in;
         baddr_ff    <= baddr_in;
         fb_ff       <= fb_in;
         free_ff     <= FREE_W'(depth_next);
         all_free_ff <= (depth_next == POOL_DEPTH);
      end
   end

   // free index stack
   always_ff @(posedge clock) begin
      if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
      if (stk_re) stk_q_ff <= stack_mem[stk_raddr];
   end

   // used bits
   always_ff @(posedge clock) begin
      if (used_we) used_mem[used_waddr] <= used_wdata;
      if (used_re) used_q_ff <= used_mem[used_raddr];
   end

   // a grant pops exactly one entry
   a_grant_pops: assert property (@(posedge clock) disable iff (reset)
      update_fire && grant |=> depth_ff == $past(depth_ff) - DEPTH_W'(1))
      else $error("grant did not pop the free stack");

   // a free or move pushes exactly one entry
   a_release_pushes: assert property (@(posedge clock) disable iff (reset)
      update_fire && release_blk |=> depth_ff == $past(depth_ff) + DEPTH_W'(1))
      else $error("release did not push the free stack");

   // an error response leaves the pool untouched
   a_error_holds: assert property (@(posedge clock) disable iff (reset)
      update_fire && (status_in == STAT_ERROR) |=> $stable(depth_ff))
      else $error("error response changed the stack depth");

   // no request write-back reaches the memories outside the update step
   a_write_in_update: assert property (@(posedge clock) disable iff (reset)
      (stk_we || used_we) && !clearing |-> state_ff == FSM_UPDATE)
      else $error("memory written outside init pass and update step");

   // the depth stays within the pool
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      update_fire |=> depth_ff <= POOL_DEPTH)
      else $error("stack depth beyond pool size");

endmodule

[tb/sv/tb_fixed_block_pool_allocator_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator_unit
// Self-checking bench for the block pool allocator. Requests go in through a
// queued driver with random gaps. A shadow pool (free-index stack, used bits,
// base register) computes each response when its request transfer is taken.
// The response monitor stalls at random and checks every field against the
// oldest prediction. Phases at several base addresses cover odd sizes,
// foreign and boundary addresses, and bursts of allocations and frees.
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_allocator_unit import fbpa_pkg::*; ();

   localparam int unsigned    POOL_N      = POOL_BLOCKS_DEF;
   localparam int unsigned    BLK_SZ      = BLOCK_BYTES_DEF;
   localparam logic [63:0]    POOL_SPAN   = 64'(POOL_N) * 64'(BLK_SZ);
   localparam logic [1:0]     REQ_UNKNOWN = 2'd3;
   localparam longint         TIMEOUT_NS  = 20_000_000;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] kind;
      logic [BYTES_W-1:0]    nbytes;
      logic [ADDR_W-1:0]     addr;
   } pool_request_type;

   typedef struct {
      status_type        status;
      logic [ADDR_W-1:0] block_address;
      logic [FB_W-1:0]   fallback_bytes;
      logic [FREE_W-1:0] free_blocks;
      logic              pool_all_free;
   } pool_result_type;

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic [ADDR_W-1:0] csr_write_data;

   fbpa_req_if req_chan ();
   fbpa_rsp_if rsp_chan ();

   fixed_block_pool_allocator_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // shadow pool state
   int unsigned       free_stack [POOL_N];
   bit                block_used [POOL_N];
   int unsigned       stack_count;
   int unsigned       min_free;
   int unsigned       allocs_on_empty;
   logic [ADDR_W-1:0] pool_base;

   pool_request_type request_backlog [$];
   pool_result_type  predicted_responses [$];
   pool_request_type in_flight;

   int requests_accepted;
   int mismatch_count;
   int status_seen [8];
   int send_gap;
   int send_calm;
   int hold_off;
   int rsp_calm;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #(TIMEOUT_NS);
      $display("Verification failed");
      $finish;
   end

   // random idle length: mostly short, a few long, with calm stretches of none
   function automatic int pick_gap(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 45) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   function automatic logic [ADDR_W-1:0] random_address();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // owned when base <= addr < base + span; any byte inside a block maps to it
   function automatic bit owning_block(input logic [ADDR_W-1:0] a, output int unsigned idx);
      logic [63:0] off;
      idx = 0;
      if (a < pool_base) return 1'b0;
      off = 64'(a) - 64'(pool_base);
      if (off >= POOL_SPAN) return 1'b0;
      idx = int'(off / BLK_SZ);
      return 1'b1;
   endfunction

   // push a block back on the free stack; no change on a fault
   function automatic bit return_block(input int unsigned idx);
      if (idx >= POOL_N || !block_used[idx] || stack_count >= POOL_N) return 1'b0;
      block_used[idx]         = 1'b0;
      free_stack[stack_count] = idx;
      stack_count++;
      return 1'b1;
   endfunction

   // apply one request to the shadow pool and queue the response it yields
   function automatic void predict_response(input pool_request_type rq);
      pool_result_type r;
      logic [63:0]     rounded;
      int unsigned     idx;
      r.status         = STAT_ERROR;
      r.block_address  = '0;
      r.fallback_bytes = '0;
      case (rq.kind)
         REQ_ALLOC: begin
            rounded = (64'(rq.nbytes) + ALLOC_ALIGN - 1) / ALLOC_ALIGN * ALLOC_ALIGN;
            if (rounded <= BLK_SZ && stack_count > 0) begin
               idx = free_stack[stack_count - 1];
               if (!block_used[idx]) begin
                  stack_count--;
                  block_used[idx] = 1'b1;
                  r.status        = STAT_GRANT;
                  r.block_address = pool_base + ADDR_W'(64'(idx) * BLK_SZ);
               end
            end else begin
               if (rounded <= BLK_SZ) allocs_on_empty++;
               r.status         = STAT_GENERAL;
               r.fallback_bytes = rounded[FB_W-1:0];
            end
         end
         REQ_FREE: begin
            if (owning_block(rq.addr, idx)) begin
               if (return_block(idx)) begin
                  r.status        = STAT_FREED;
                  r.block_address = rq.addr;
               end
            end else begin
               r.status        = STAT_FOREIGN_FREE;
               r.block_address = rq.addr;
            end
         end
         REQ_RESIZE: begin
            if (owning_block(rq.addr, idx)) begin
               // a fitting size keeps the block without looking at its used bit
               if (rq.nbytes <= BLK_SZ) begin
                  r.status        = STAT_KEPT;
                  r.block_address = rq.addr;
               end else if (return_block(idx)) begin
                  r.status         = STAT_MOVED;
                  r.block_address  = rq.addr;
                  r.fallback_bytes = FB_W'(rq.nbytes);
               end
            end else begin
               r.status         = STAT_FOREIGN_RESIZE;
               r.block_address  = rq.addr;
               r.fallback_bytes = FB_W'(rq.nbytes);
            end
         end
         default: ;
      endcase
      r.free_blocks   = FREE_W'(stack_count);
      r.pool_all_free = (stack_count == POOL_N);
      if (stack_count < min_free) min_free = stack_count;
      predicted_responses.insert(predicted_responses.size(), r);
   endfunction

   function automatic void field_check(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // address inside a used block, any block, a range edge or anywhere at all
   function automatic logic [ADDR_W-1:0] pick_target(input int used_pct);
      int unsigned idx;
      int unsigned k;
      int          r;
      r   = $urandom_range(0, 99);
      idx = $urandom_range(0, POOL_N - 1);
      if (r < used_pct && stack_count < POOL_N) begin
         for (k = 0; k < POOL_N && !block_used[idx]; k++) idx = (idx + 1) % POOL_N;
         return pool_base + ADDR_W'(idx * BLK_SZ + $urandom_range(0, BLK_SZ - 1));
      end
      r = $urandom_range(0, 9);
      if (r < 5) return pool_base + ADDR_W'(idx * BLK_SZ + $urandom_range(0, BLK_SZ - 1));
      if (r < 7) begin
         case ($urandom_range(0, 2))
            0:       return pool_base - 1;
            1:       return pool_base + ADDR_W'(POOL_SPAN);
            default: return pool_base + ADDR_W'(POOL_SPAN - 1);
         endcase
      end
      return random_address();
   endfunction

   task automatic queue_request(input logic [1:0] kind, input logic [BYTES_W-1:0] nbytes,
                                input logic [ADDR_W-1:0] addr);
      pool_request_type rq;
      rq.kind   = kind;
      rq.nbytes = nbytes;
      rq.addr   = addr;
      request_backlog.insert(request_backlog.size(), rq);
   endtask

   // one random request, generated against the current shadow pool
   task automatic make_request(input int alloc_w, input int free_w, input int resize_w,
                               input int used_pct);
      int                   r;
      int                   s;
      logic [BYTES_W-1:0]   nb;
      while (request_backlog.size() != 0) @(negedge clock);
      r = $urandom_range(0, 99);
      s = $urandom_range(0, 99);
      if (r < alloc_w) begin
         if (s < 70)      nb = $urandom_range(0, BLK_SZ);
         else if (s < 82) nb = $urandom_range(BLK_SZ - 8, BLK_SZ + 8);
         else             nb = $urandom;
         queue_request(REQ_ALLOC, nb, random_address());
      end else if (r < alloc_w + free_w) begin
         queue_request(REQ_FREE, $urandom, pick_target(used_pct));
      end else if (r < alloc_w + free_w + resize_w) begin
         if (s < 45)      nb = $urandom_range(0, BLK_SZ);
         else if (s < 55) nb = $urandom_range(BLK_SZ, BLK_SZ + 1);
         else if (s < 85) nb = $urandom_range(BLK_SZ + 1, 8 * BLK_SZ);
         else             nb = $urandom;
         queue_request(REQ_RESIZE, nb, pick_target(used_pct));
      end else begin
         queue_request(REQ_UNKNOWN, $urandom, random_address());
      end
   endtask

   // idle: nothing queued, nothing on the wire, nothing outstanding
   task automatic wait_for_quiet();
      while (request_backlog.size() != 0 || req_chan.valid ||
             predicted_responses.size() != 0) @(negedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_pool_base(input logic [ADDR_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      pool_base = value;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid         <= 1'b0;
         req_chan.req_type      <= '0;
         req_chan.request_bytes <= '0;
         req_chan.address       <= '0;
         send_gap               <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_response(in_flight);
            requests_accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap       <= send_gap - 1;
               req_chan.valid <= 1'b0;
            end else if (request_backlog.size() > 0) begin
               in_flight               = request_backlog.pop_front();
               req_chan.req_type      <= in_flight.kind;
               req_chan.request_bytes <= in_flight.nbytes;
               req_chan.address       <= in_flight.addr;
               req_chan.valid         <= 1'b1;
               send_gap               <= pick_gap(send_calm);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin : rsp_monitor
      pool_result_type want;
      int              g;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_off       <= 0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         if (predicted_responses.size() == 0) begin
            $error("response transfer with no request pending: status %0d", rsp_chan.status);
            mismatch_count++;
         end else begin
            want = predicted_responses.pop_front();
            status_seen[want.status]++;
            field_check("status", 64'(want.status), 64'(rsp_chan.status));
            field_check("block_address", 64'(want.block_address), 64'(rsp_chan.block_address));
            field_check("fallback_bytes", 64'(want.fallback_bytes),
                        64'(rsp_chan.fallback_bytes));
            field_check("free_blocks", 64'(want.free_blocks), 64'(rsp_chan.free_blocks));
            field_check("pool_all_free", 64'(want.pool_all_free), 64'(rsp_chan.pool_all_free));
         end
         g = pick_gap(rsp_calm);
         hold_off       <= g;
         rsp_chan.ready <= (g == 0);
      end else if (hold_off > 0) begin
         hold_off       <= hold_off - 1;
         rsp_chan.ready <= (hold_off == 1);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // stimulus and phase control
   initial begin : stimulus
      int n;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      for (int i = 0; i < POOL_N; i++) begin
         free_stack[i] = i;
         block_used[i] = 1'b0;
      end
      stack_count = POOL_N;
      min_free    = POOL_N;
      pool_base   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: size rounding edges, every status, boundaries, bad kind
      write_pool_base('0);
      queue_request(REQ_ALLOC, 32'd0, '0);
      queue_request(REQ_ALLOC, 32'd1, '1);
      queue_request(REQ_ALLOC, BLK_SZ - 7, '0);
      queue_request(REQ_ALLOC, BLK_SZ, '0);
      queue_request(REQ_ALLOC, BLK_SZ + 1, '0);
      queue_request(REQ_ALLOC, 32'hFFFF_FFFF, '0);
      queue_request(REQ_ALLOC, 32'hFFFF_FFF8, '0);
      queue_request(REQ_FREE, '0, ADDR_W'(1023 * BLK_SZ + 5));
      queue_request(REQ_FREE, '0, ADDR_W'(1023 * BLK_SZ));      // double free
      queue_request(REQ_FREE, '1, '0);                           // block never handed out
      queue_request(REQ_FREE, '0, ADDR_W'(POOL_SPAN));
      queue_request(REQ_FREE, '0, '1);
      queue_request(REQ_RESIZE, BLK_SZ, ADDR_W'(1022 * BLK_SZ));
      queue_request(REQ_RESIZE, 32'd0, ADDR_W'(5 * BLK_SZ));     // fits, unused block
      queue_request(REQ_RESIZE, BLK_SZ + 1, ADDR_W'(1022 * BLK_SZ + 1023));
      queue_request(REQ_RESIZE, 32'hFFFF_FFFF, ADDR_W'(5 * BLK_SZ));
      queue_request(REQ_RESIZE, 32'd16, ADDR_W'(POOL_SPAN - 1));
      queue_request(REQ_RESIZE, 32'd2000, ADDR_W'(POOL_SPAN));
      queue_request(REQ_UNKNOWN, 32'hFFFF_FFFF, '1);
      queue_request(REQ_ALLOC, 32'd8, '0);
      queue_request(REQ_FREE, '0, ADDR_W'(1021 * BLK_SZ));
      queue_request(REQ_FREE, '0, ADDR_W'(1020 * BLK_SZ + 1023));
      queue_request(REQ_FREE, '0, ADDR_W'(1022 * BLK_SZ));
      wait_for_quiet();

      // mixed traffic, base in the lower part of the address space
      write_pool_base(random_address() >> 2);
      for (n = 0; n < 150; n++) make_request(45, 25, 26, 75);
      wait_for_quiet();

      // unaligned base: an allocation burst, then mostly frees
      write_pool_base((random_address() >> 1) | ADDR_W'(3));
      for (n = 0; n < 100; n++) make_request(90, 5, 5, 75);
      for (n = 0; n < 60; n++) make_request(4, 80, 15, 95);
      wait_for_quiet();

      // top base: grant addresses wrap and almost nothing is owned
      write_pool_base('1);
      for (n = 0; n < 30; n++) make_request(45, 25, 26, 75);
      wait_for_quiet();

      // pool range cut off by the top of the address space
      write_pool_base('1 - ADDR_W'(300 * BLK_SZ) + ADDR_W'(24));
      for (n = 0; n < 40; n++) make_request(45, 25, 26, 75);
      wait_for_quiet();
      repeat (10) @(posedge clock);

      $write("Covered %0d requests at five base settings: ", requests_accepted);
      $display("grant %0d, general %0d, freed %0d, moved %0d, kept %0d, error %0d",
               status_seen[STAT_GRANT], status_seen[STAT_GENERAL],
               status_seen[STAT_FREED], status_seen[STAT_MOVED], status_seen[STAT_KEPT],
               status_seen[STAT_ERROR]);
      $display("Small allocations on an empty pool: %0d, lowest free count: %0d",
               allocs_on_empty, min_free);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/fbpa_pkg.sv
hdl/fbpa_req_if.sv
hdl/fbpa_rsp_if.sv
hdl/fixed_block_pool_allocator_unit.sv
tb/sv/tb_fixed_block_pool_allocator_unit.sv
